FILE: design/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the world-to-screen projection block.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned THR_W   = 31;

  // Projected values are clamped to +-2^PROJ_BITS
  localparam int unsigned PROJ_BITS = 40;

  // Scale for points behind the threshold, and the largest input it may take
  localparam longint unsigned BEHIND_SCALE   = 100000;
  localparam longint unsigned BEHIND_LIMIT   = (64'd1 << PROJ_BITS) / BEHIND_SCALE;
  localparam int unsigned     BEHIND_LIMIT_W = $clog2(BEHIND_LIMIT + 1) + 1;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } wsp_point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic                      visible;
  } wsp_screen_t;

  // Rows 0, 1 and 3 of the matrix at indices 0, 1 and 2; four columns each
  typedef logic [2:0][3:0][COORD_W-1:0] wsp_matrix_t;

  typedef struct packed {
    wsp_matrix_t      matrix;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [THR_W-1:0] w_threshold;
  } wsp_cfg_t;

  typedef enum logic [2:0] {
    CFG_ROW0_XY     = 3'd0,
    CFG_ROW0_ZW     = 3'd1,
    CFG_ROW1_XY     = 3'd2,
    CFG_ROW1_ZW     = 3'd3,
    CFG_ROW3_XY     = 3'd4,
    CFG_ROW3_ZW     = 3'd5,
    CFG_SCREEN_SIZE = 3'd6,
    CFG_W_THRESHOLD = 3'd7
  } wsp_cfg_e;

endpackage

FILE: design/wsp_front.sv
// ----------------------------------------------------------------------------
// wsp_front
// Forms clip x, clip y and w from the point and classifies it as visible.
// ----------------------------------------------------------------------------
module wsp_front #(
  parameter int unsigned FRAC  = 16,
  parameter int unsigned ACC_W = 50
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  wsp_pkg::wsp_point_t                  point_i,
  input  wsp_pkg::wsp_matrix_t                 matrix_i,
  input  logic [wsp_pkg::THR_W-1:0]            w_threshold_i,
  output logic                                 push_o,
  output logic                                 vis_o,
  output logic signed [ACC_W-1:0]              clip_x_o,
  output logic signed [ACC_W-1:0]              clip_y_o,
  output logic signed [ACC_W-1:0]              clip_w_o
);

  localparam int unsigned PROD_W = 2 * wsp_pkg::COORD_W;

  logic signed [wsp_pkg::COORD_W-1:0] pt [3];
  logic signed [PROD_W-1:0]           prod_d [3][3];
  logic signed [PROD_W-1:0]           prod_q [3][3];
  logic signed [ACC_W-1:0]            acc_d [3];
  logic signed [ACC_W-1:0]            acc_q [3];
  logic                               v1_q, v2_q;
  logic [wsp_pkg::THR_W-1:0]          thr_eff;
  logic signed [ACC_W-1:0]            thr_ext;

  assign pt[0] = point_i.point_x;
  assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;

  // Multiply each coefficient by its coordinate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = PROD_W'($signed(matrix_i[r][c])) * PROD_W'(pt[c]);
      end
    end
  end

  // Drop the fraction (floor) and add the row's constant term
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_d[r] = ACC_W'($signed(prod_q[r][0][PROD_W-1:FRAC]))
               + ACC_W'($signed(prod_q[r][1][PROD_W-1:FRAC]))
               + ACC_W'($signed(prod_q[r][2][PROD_W-1:FRAC]))
               + ACC_W'($signed(matrix_i[r][3]));
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Classify: a zero threshold acts as one
  assign thr_eff = (w_threshold_i == '0) ? wsp_pkg::THR_W'(1) : w_threshold_i;
  assign thr_ext = $signed({{(ACC_W - wsp_pkg::THR_W){1'b0}}, thr_eff});

  assign push_o   = v2_q;
  assign vis_o    = acc_q[2] >= thr_ext;
  assign clip_x_o = acc_q[0];
  assign clip_y_o = acc_q[1];
  assign clip_w_o = acc_q[2];

endmodule

FILE: design/wsp_queue.sv
// ----------------------------------------------------------------------------
// wsp_queue
// Short first-in first-out queue between front and back, registered read.
// ----------------------------------------------------------------------------
module wsp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   level_o,
  output logic                         valid_o,
  output logic [WIDTH-1:0]             data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  // Advance pointers and the fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      cnt_q   <= cnt_d;
      valid_q <= pop_i;
    end
  end

  // Store the request and read the oldest one
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
    if (pop_i) begin
      data_q <= mem[rd_q];
    end
  end

  assign empty_o = (cnt_q == '0);
  assign level_o = cnt_q;
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/wsp_div.sv
// ----------------------------------------------------------------------------
// wsp_div
// Two-lane pipelined restoring divider, one quotient bit per stage,
// quotient of mag * 2^FRAC / den clamped to 2^PROJ_BITS.
// ----------------------------------------------------------------------------
module wsp_div #(
  parameter int unsigned ACC_W  = 50,
  parameter int unsigned FRAC   = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [ACC_W-1:0]                 mag_i [2],
  input  logic [ACC_W-1:0]                 den_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic [wsp_pkg::PROJ_BITS:0]      quot_o [2],
  output logic [SIDE_W-1:0]                side_o
);

  localparam int unsigned QB   = wsp_pkg::PROJ_BITS + 1;
  localparam int unsigned DW   = ACC_W + FRAC;
  localparam int unsigned HI_W = DW - QB;
  localparam logic [QB-1:0] Q_LIMIT = QB'(1) << wsp_pkg::PROJ_BITS;

  logic [DW-1:0]     dvd [2];
  logic [HI_W-1:0]   hi [2];
  logic [ACC_W-1:0]  rem_d [QB+1][2];
  logic [ACC_W-1:0]  rem_q [QB+1][2];
  logic [QB-1:0]     low_d [QB+1][2];
  logic [QB-1:0]     low_q [QB+1][2];
  logic [QB-1:0]     quo_d [QB+1][2];
  logic [QB-1:0]     quo_q [QB+1][2];
  logic              sat_d [QB+1][2];
  logic              sat_q [QB+1][2];
  logic [ACC_W-1:0]  den_d [QB+1];
  logic [ACC_W-1:0]  den_q [QB+1];
  logic [SIDE_W-1:0] side_d [QB+1];
  logic [SIDE_W-1:0] side_q [QB+1];
  logic [QB:0]       valid_d, valid_q;
  logic [ACC_W:0]    trial [1:QB][2];
  logic              ge [1:QB][2];

  always_comb begin
    // Entry: split the dividend, flag a quotient that cannot fit
    for (int l = 0; l < 2; l++) begin
      dvd[l]      = {mag_i[l], {FRAC{1'b0}}};
      hi[l]       = dvd[l][DW-1:QB];
      rem_d[0][l] = ACC_W'(hi[l]);
      low_d[0][l] = dvd[l][QB-1:0];
      quo_d[0][l] = '0;
      sat_d[0][l] = ACC_W'(hi[l]) >= den_i;
    end
    den_d[0]   = den_i;
    side_d[0]  = side_i;
    valid_d[0] = valid_i;

    // One quotient bit per stage
    for (int k = 1; k <= QB; k++) begin
      for (int l = 0; l < 2; l++) begin
        trial[k][l] = {rem_q[k-1][l], low_q[k-1][l][QB-1]};
        ge[k][l]    = trial[k][l] >= {1'b0, den_q[k-1]};
        rem_d[k][l] = ge[k][l] ? ACC_W'(trial[k][l] - {1'b0, den_q[k-1]})
                               : trial[k][l][ACC_W-1:0];
        low_d[k][l] = {low_q[k-1][l][QB-2:0], 1'b0};
        quo_d[k][l] = {quo_q[k-1][l][QB-2:0], ge[k][l]};
        sat_d[k][l] = sat_q[k-1][l];
      end
      den_d[k]   = den_q[k-1];
      side_d[k]  = side_q[k-1];
      valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quo_q  <= quo_d;
    sat_q  <= sat_d;
    den_q  <= den_d;
    side_q <= side_d;
  end

  // Clamp the quotient
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quot_o[l] = (sat_q[QB][l] || (quo_q[QB][l] > Q_LIMIT)) ? Q_LIMIT : quo_q[QB][l];
    end
  end

  assign valid_o = valid_q[QB];
  assign side_o  = side_q[QB];

endmodule

FILE: design/wsp_back.sv
// ----------------------------------------------------------------------------
// wsp_back
// Projects clip x and y (divide by w or scale up), then maps them to pixels.
// ----------------------------------------------------------------------------
module wsp_back #(
  parameter int unsigned FRAC  = 16,
  parameter int unsigned ACC_W = 50
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          vis_i,
  input  logic signed [ACC_W-1:0]       clip_x_i,
  input  logic signed [ACC_W-1:0]       clip_y_i,
  input  logic signed [ACC_W-1:0]       clip_w_i,
  input  logic [wsp_pkg::DIM_W-1:0]     width_i,
  input  logic [wsp_pkg::DIM_W-1:0]     height_i,
  output logic                          done_o,
  output wsp_pkg::wsp_screen_t          screen_o
);

  localparam int unsigned SQ_W   = wsp_pkg::PROJ_BITS + 2;
  localparam int unsigned SIDE_W = 3 + 2 * SQ_W;
  localparam int unsigned LIM_W  = wsp_pkg::BEHIND_LIMIT_W;
  localparam int unsigned OFF_W  = SQ_W + wsp_pkg::DIM_W + 1;
  localparam int unsigned NUM_W  = OFF_W + 1;
  localparam int unsigned QW     = wsp_pkg::PROJ_BITS + 1;

  localparam logic signed [ACC_W-1:0] LIM_P = $signed(ACC_W'(wsp_pkg::BEHIND_LIMIT));
  localparam logic signed [ACC_W-1:0] LIM_N = -LIM_P;
  localparam logic signed [SQ_W-1:0]  PROJ_P = $signed(SQ_W'(1) << wsp_pkg::PROJ_BITS);
  localparam logic signed [SQ_W-1:0]  PROJ_N = -PROJ_P;
  localparam logic signed [SQ_W-1:0]  SCALE_K = $signed(SQ_W'(wsp_pkg::BEHIND_SCALE));
  localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'(32'sh7fff_ffff);
  localparam logic signed [NUM_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [ACC_W-1:0] clip [2];
  logic                    neg [2];
  logic [ACC_W-1:0]        mag [2];
  logic signed [SQ_W-1:0]  scaled [2];
  logic [SIDE_W-1:0]       side_in, side_out;
  logic                    div_valid;
  logic [QW-1:0]           quot [2];
  logic signed [SQ_W-1:0]  sdiv [2];
  logic signed [SQ_W-1:0]  sel_d [2];
  logic signed [SQ_W-1:0]  sel_q [2];
  logic                    sel_vis_q, sel_v_q;
  logic signed [OFF_W-1:0] off_d [2];
  logic signed [OFF_W-1:0] off_q [2];
  logic                    off_vis_q, off_v_q;
  logic [wsp_pkg::DIM_W-1:0] dim [2];
  logic signed [NUM_W-1:0] base [2];
  logic signed [NUM_W-1:0] num [2];
  logic signed [NUM_W-1:0] half [2];
  logic signed [wsp_pkg::COORD_W-1:0] pix [2];
  wsp_pkg::wsp_screen_t    screen_q;
  logic                    done_q;

  assign clip[0] = clip_x_i;
  assign clip[1] = clip_y_i;
  assign dim[0]  = width_i;
  assign dim[1]  = height_i;

  // Split sign and magnitude for the divider, form the scaled-up value
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      neg[a] = clip[a][ACC_W-1];
      mag[a] = neg[a] ? ACC_W'(-clip[a]) : clip[a];
      if (clip[a] > LIM_P) begin
        scaled[a] = PROJ_P;
      end else if (clip[a] < LIM_N) begin
        scaled[a] = PROJ_N;
      end else begin
        scaled[a] = SQ_W'($signed(clip[a][LIM_W-1:0])) * SCALE_K;
      end
    end
  end

  assign side_in = {vis_i, neg[0], neg[1], scaled[0], scaled[1]};

  wsp_div #(
    .ACC_W (ACC_W),
    .FRAC  (FRAC),
    .SIDE_W(SIDE_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .mag_i  (mag),
    .den_i  (clip_w_i),
    .side_i (side_in),
    .valid_o(div_valid),
    .quot_o (quot),
    .side_o (side_out)
  );

  // Pick the divided or the scaled value
  always_comb begin
    sdiv[0]  = $signed({1'b0, quot[0]});
    sdiv[1]  = $signed({1'b0, quot[1]});
    sel_d[0] = side_out[SIDE_W-1]
             ? (side_out[SIDE_W-2] ? -sdiv[0] : sdiv[0])
             : $signed(side_out[2*SQ_W-1:SQ_W]);
    sel_d[1] = side_out[SIDE_W-1]
             ? (side_out[SIDE_W-3] ? -sdiv[1] : sdiv[1])
             : $signed(side_out[SQ_W-1:0]);
  end

  // Scale by the screen dimension
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      off_d[a] = OFF_W'(sel_q[a]) * OFF_W'($signed({1'b0, dim[a]}));
    end
  end

  // Offset by half the screen, halve and saturate
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      base[a] = $signed(NUM_W'(dim[a]) << FRAC);
      num[a]  = (a == 0) ? base[a] + NUM_W'(off_q[a]) : base[a] - NUM_W'(off_q[a]);
      half[a] = num[a] >>> 1;
      if (half[a] > SAT_HI) begin
        pix[a] = SAT_HI[wsp_pkg::COORD_W-1:0];
      end else if (half[a] < SAT_LO) begin
        pix[a] = SAT_LO[wsp_pkg::COORD_W-1:0];
      end else begin
        pix[a] = half[a][wsp_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q             <= sel_d;
    sel_vis_q         <= side_out[SIDE_W-1];
    off_q             <= off_d;
    off_vis_q         <= sel_vis_q;
    screen_q.screen_x <= pix[0];
    screen_q.screen_y <= pix[1];
    screen_q.visible  <= off_vis_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_v_q <= 1'b0;
      off_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      sel_v_q <= div_valid;
      off_v_q <= sel_v_q;
      done_q  <= off_v_q;
    end
  end

  assign done_o   = done_q;
  assign screen_o = screen_q;

endmodule

FILE: design/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects a world point through the view-projection matrix onto the screen.
// The divider pipeline (one quotient bit per stage) sets most of the latency
//   from the start request to done_o.
// Throughput: one request per cycle; busy_o stays low in normal use.
// Reset: asynchronous, clears all control and loads the identity matrix,
//   a 1920 x 1080 screen and a threshold of 66. The receiver cannot stall.
// ----------------------------------------------------------------------------
module world_to_screen_projection #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  wsp_pkg::wsp_point_t   point_i,
  output logic                  done_o,
  output wsp_pkg::wsp_screen_t  screen_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [63:0]           cfg_wdata_i
);

  localparam int unsigned ACC_W   = 66 - FRACTION_BITS;
  localparam int unsigned Q_WIDTH = 1 + 3 * ACC_W;
  localparam int unsigned LVL_W   = $clog2(wsp_pkg::QUEUE_DEPTH + 1);

  localparam logic [31:0] FX_ONE = 32'h0001_0000;

  // Register file after reset: identity rows, 1920 x 1080 screen, threshold 66
  localparam wsp_pkg::wsp_cfg_t CFG_RESET = '{
    matrix:      {FX_ONE, 32'd0, 32'd0, 32'd0,    // row 3
                  32'd0, 32'd0, FX_ONE, 32'd0,    // row 1
                  32'd0, 32'd0, 32'd0, FX_ONE},   // row 0
    width:       16'd1920,
    height:      16'd1080,
    w_threshold: 31'd66
  };

  wsp_pkg::wsp_cfg_t       cfg_q, cfg_d;
  logic                    push, vis;
  logic signed [ACC_W-1:0] clip_x, clip_y, clip_w;
  logic                    q_empty, q_valid, pop;
  logic [LVL_W-1:0]        q_level;
  logic [Q_WIDTH-1:0]      q_in, q_out;

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (wsp_pkg::wsp_cfg_e'(cfg_index_i))
        wsp_pkg::CFG_ROW0_XY: begin
          cfg_d.matrix[0][0] = cfg_wdata_i[31:0];
          cfg_d.matrix[0][1] = cfg_wdata_i[63:32];
        end
        wsp_pkg::CFG_ROW0_ZW: begin
          cfg_d.matrix[0][2] = cfg_wdata_i[31:0];
          cfg_d.matrix[0][3] = cfg_wdata_i[63:32];
        end
        wsp_pkg::CFG_ROW1_XY: begin
          cfg_d.matrix[1][0] = cfg_wdata_i[31:0];
          cfg_d.matrix[1][1] = cfg_wdata_i[63:32];
        end
        wsp_pkg::CFG_ROW1_ZW: begin
          cfg_d.matrix[1][2] = cfg_wdata_i[31:0];
          cfg_d.matrix[1][3] = cfg_wdata_i[63:32];
        end
        wsp_pkg::CFG_ROW3_XY: begin
          cfg_d.matrix[2][0] = cfg_wdata_i[31:0];
          cfg_d.matrix[2][1] = cfg_wdata_i[63:32];
        end
        wsp_pkg::CFG_ROW3_ZW: begin
          cfg_d.matrix[2][2] = cfg_wdata_i[31:0];
          cfg_d.matrix[2][3] = cfg_wdata_i[63:32];
        end
        wsp_pkg::CFG_SCREEN_SIZE: begin
          cfg_d.width  = cfg_wdata_i[15:0];
          cfg_d.height = cfg_wdata_i[31:16];
        end
        wsp_pkg::CFG_W_THRESHOLD: begin
          cfg_d.w_threshold = cfg_wdata_i[30:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Hold requests off only if the queue could overflow with the front in flight
  assign busy_o = (q_level >= LVL_W'(wsp_pkg::QUEUE_DEPTH - 2));

  wsp_front #(
    .FRAC (FRACTION_BITS),
    .ACC_W(ACC_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start_i && !busy_o),
    .point_i      (point_i),
    .matrix_i     (cfg_q.matrix),
    .w_threshold_i(cfg_q.w_threshold),
    .push_o       (push),
    .vis_o        (vis),
    .clip_x_o     (clip_x),
    .clip_y_o     (clip_y),
    .clip_w_o     (clip_w)
  );

  assign q_in = {vis, clip_x, clip_y, clip_w};
  assign pop  = !q_empty;

  wsp_queue #(
    .WIDTH(Q_WIDTH),
    .DEPTH(wsp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .pop_i  (pop),
    .empty_o(q_empty),
    .level_o(q_level),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  wsp_back #(
    .FRAC (FRACTION_BITS),
    .ACC_W(ACC_W)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .vis_i   (q_out[Q_WIDTH-1]),
    .clip_x_i($signed(q_out[3*ACC_W-1:2*ACC_W])),
    .clip_y_i($signed(q_out[2*ACC_W-1:ACC_W])),
    .clip_w_i($signed(q_out[ACC_W-1:0])),
    .width_i (cfg_q.width),
    .height_i(cfg_q.height),
    .done_o  (done_o),
    .screen_o(screen_o)
  );

endmodule
